[sv/mtg_pkg.sv]
// mtg_pkg: shared types, constants and the tempering function of the
// mersenne twister generator; no dependencies
`timescale 1ns / 1ps

package mtg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int QUEUE_DEPTH  = 2;
    localparam int WORD_W       = 32;
    localparam int INDEX_W      = 10;

    localparam logic [INDEX_W-1:0] INDEX_FULL     = INDEX_W'(STATE_WORDS);
    localparam logic [INDEX_W-1:0] INDEX_UNSEEDED = INDEX_W'(STATE_WORDS + 1);
    localparam logic [INDEX_W-1:0] INDEX_LAST     = INDEX_W'(STATE_WORDS - 1);

    localparam logic [WORD_W-1:0] DEFAULT_SEED  = 32'd5489;
    localparam logic [WORD_W-1:0] INIT_MULT     = 32'd1812433253;
    localparam logic [WORD_W-1:0] TWIST_MATRIX  = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_MASK_B = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_MASK_C = 32'hefc6_0000;

    typedef enum logic {
        CMD_DRAW,
        CMD_RESEED_DRAW
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED0,
        ST_FILL_MUL,
        ST_FILL_WR,
        ST_TW_START,
        ST_TW_CUR,
        ST_TW_RD_NEXT,
        ST_TW_RD_FAR,
        ST_TW_WRITE,
        ST_DRAW_RD,
        ST_DRAW_WAIT,
        ST_OUT
    } t_state;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_MASK_B);
        y = y ^ ((y << 15) & TEMPER_MASK_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

[sv/mtg_ram.sv]
// mtg_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/mtg_front.sv]
// mtg_front: request intake register, turns the reseed flag into a command
// depends on mtg_pkg
`timescale 1ns / 1ps

module mtg_front
    import mtg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_reseed,
    input  logic i_q_full,
    output logic o_push,
    output t_cmd o_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    logic accept;

    assign o_in_stall = r_valid & i_q_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_valid & ~i_q_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.kind <= i_reseed ? CMD_RESEED_DRAW : CMD_DRAW;
        end
    end

endmodule

[sv/mtg_queue.sv]
// mtg_queue: short command fifo between intake and generator engine
// depends on mtg_pkg
`timescale 1ns / 1ps

module mtg_queue
    import mtg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_slots [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_FULL);
    assign do_push        = i_push & ~o_status.full;
    assign do_pop         = i_pop & ~o_status.empty;
    assign o_cmd          = r_slots[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wptr] <= i_cmd;
        end
    end

endmodule

[sv/mtg_back.sv]
// mtg_back: generator engine with state store, seeding, twist, draw and output
// register; depends on mtg_pkg and mtg_ram
`timescale 1ns / 1ps

module mtg_back
    import mtg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    input  logic              i_cfg_valid,
    input  logic [WORD_W-1:0] i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [WORD_W-1:0] o_random_word
);

    localparam int ADDR_W = $clog2(STATE_WORDS);
    localparam logic [INDEX_W:0] FAR_WRAP = (INDEX_W + 1)'(STATE_WORDS);

    t_state              r_state;
    t_state              n_state;
    logic [WORD_W-1:0]   r_seed;
    logic [INDEX_W-1:0]  r_index;
    logic [INDEX_W-1:0]  n_index;
    logic [INDEX_W-1:0]  r_ptr;
    logic [INDEX_W-1:0]  n_ptr;
    logic [WORD_W-1:0]   r_prev;
    logic [WORD_W-1:0]   n_prev;
    logic [WORD_W-1:0]   r_prod;
    logic [WORD_W-1:0]   r_cur;
    logic [WORD_W-1:0]   r_next;
    logic [WORD_W-1:0]   r_word;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [WORD_W-1:0]   r_out_word;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic [WORD_W-1:0]   fill_word;
    logic [WORD_W-1:0]   twist_y;
    logic [WORD_W-1:0]   twist_word;
    logic [INDEX_W-1:0]  ptr_succ;
    logic [INDEX_W:0]    far_sum;
    logic [INDEX_W-1:0]  far_addr;
    logic                out_free;

    mtg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign fill_word  = r_prod + WORD_W'(r_ptr);
    assign ptr_succ   = (r_ptr == INDEX_LAST) ? '0 : r_ptr + 1'b1;
    assign far_sum    = {1'b0, r_ptr} + (INDEX_W + 1)'(TWIST_OFFSET);
    assign far_addr   = (far_sum >= FAR_WRAP) ? INDEX_W'(far_sum - FAR_WRAP)
                                              : INDEX_W'(far_sum);
    // upper bit of the current word with the low bits of its successor
    assign twist_y    = {r_cur[WORD_W-1], r_next[WORD_W-2:0]};
    assign twist_word = ram_rdata ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);

    always_comb begin
        n_state     = r_state;
        n_index     = r_index;
        n_ptr       = r_ptr;
        n_prev      = r_prev;
        n_out_valid = r_out_valid & i_out_stall;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_ptr[ADDR_W-1:0];
        ram_wdata   = fill_word;
        ram_raddr   = r_index[ADDR_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == CMD_RESEED_DRAW) begin
                        n_prev  = r_seed;
                        n_state = ST_SEED0;
                    end else if (r_index == INDEX_UNSEEDED) begin
                        n_prev  = DEFAULT_SEED;
                        n_state = ST_SEED0;
                    end else if (r_index == INDEX_FULL) begin
                        n_state = ST_TW_START;
                    end else begin
                        n_state = ST_DRAW_RD;
                    end
                end
            end
            ST_SEED0: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_prev;
                n_ptr     = INDEX_W'(1);
                n_state   = ST_FILL_MUL;
            end
            ST_FILL_MUL: begin
                n_state = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                ram_we = 1'b1;
                n_prev = fill_word;
                if (r_ptr == INDEX_LAST) begin
                    n_index = INDEX_FULL;
                    n_state = ST_TW_START;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = ST_FILL_MUL;
                end
            end
            ST_TW_START: begin
                ram_raddr = '0;
                n_ptr     = '0;
                n_state   = ST_TW_CUR;
            end
            ST_TW_CUR: begin
                n_state = ST_TW_RD_NEXT;
            end
            ST_TW_RD_NEXT: begin
                ram_raddr = ptr_succ[ADDR_W-1:0];
                n_state   = ST_TW_RD_FAR;
            end
            ST_TW_RD_FAR: begin
                ram_raddr = far_addr[ADDR_W-1:0];
                n_state   = ST_TW_WRITE;
            end
            ST_TW_WRITE: begin
                ram_we    = 1'b1;
                ram_wdata = twist_word;
                if (r_ptr == INDEX_LAST) begin
                    n_index = '0;
                    n_state = ST_DRAW_RD;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = ST_TW_RD_NEXT;
                end
            end
            ST_DRAW_RD: begin
                n_state = ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT: begin
                n_index = r_index + 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_index     <= INDEX_UNSEEDED;
            r_seed      <= DEFAULT_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_index     <= n_index;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_prev <= n_prev;
        r_prod <= INIT_MULT * (r_prev ^ (r_prev >> 30));
        if (r_state == ST_TW_CUR) begin
            r_cur <= ram_rdata;
        end else if (r_state == ST_TW_WRITE) begin
            r_cur <= r_next;
        end
        if (r_state == ST_TW_RD_FAR) begin
            r_next <= ram_rdata;
        end
        if (r_state == ST_DRAW_WAIT) begin
            r_word <= temper(ram_rdata);
        end
        if (r_state == ST_OUT && out_free) begin
            r_out_word <= r_word;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_random_word = r_out_word;

endmodule

[sv/mersenne_twister_generator.sv]
// mersenne_twister_generator: top level of the 32-bit mt19937 generator
// depends on mtg_pkg, mtg_front, mtg_queue, mtg_back (and mtg_ram below it)
`timescale 1ns / 1ps

// Each request on the input channel returns one tempered 32-bit word on the
// output channel, in order. Requests are taken into an intake register and a
// short command queue, so the input side keeps moving while the engine works
// or the output is stalled, until the queue is full. The engine keeps a
// 624-word state store with one write port and one registered read port, and
// its state machine sets the pace: a plain draw reads the store, tempers the
// word and passes it to the output register; the draw that finds the store
// used up first regenerates it, one read of the successor, one read of the
// far word and one write per word; a request with reseed set, and the very
// first draw after reset, fill the store first (one multiply, then one add
// per word), followed by the regeneration. The seed register resets to 5489
// and is written through the configuration channel, which is always ready;
// write it only while no request is outstanding. A draw before any reseed
// uses seed 5489 whatever the register holds.

module mersenne_twister_generator
    import mtg_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_reseed,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [WORD_W-1:0] o_random_word,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [WORD_W-1:0] i_cfg_data
);

    logic      push;
    logic      pop;
    t_cmd      front_cmd;
    t_cmd      queue_cmd;
    t_q_status q_status;

    assign o_cfg_ready = 1'b1;

    mtg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_reseed   (i_reseed),
        .i_q_full   (q_status.full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    mtg_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    mtg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (queue_cmd),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .i_cfg_valid   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_random_word (o_random_word)
    );

endmodule

[tb/sv/mersenne_twister_generator_tb.sv]
// mersenne_twister_generator_tb: self-checking bench for the mt19937 word generator
// depends on mtg_pkg and mersenne_twister_generator; keeps its own copy of the state store
`timescale 1ns / 1ps

module mersenne_twister_generator_tb;
    import mtg_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [WORD_W-1:0] BOOT_SEED  = 32'd5489;
    localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;
    localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_stall;
    logic              i_reseed      = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall   = 1'b0;
    logic [WORD_W-1:0] o_random_word;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [WORD_W-1:0] i_cfg_data    = '0;

    // predictor state
    logic [WORD_W-1:0] word_bank [STATE_WORDS];
    int unsigned       bank_pos    = STATE_WORDS + 1;
    logic [WORD_W-1:0] seed_shadow = BOOT_SEED;

    t_cmd_kind         pending_cmds [$];
    logic [WORD_W-1:0] awaited_words [$];
    t_cmd_kind         cur_cmd     = CMD_DRAW;
    int                in_gap      = 0;
    int                stall_left  = 0;
    int                error_count = 0;
    int                cycle_count = 0;
    bit                calm        = 1'b0;

    mersenne_twister_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_reseed      (i_reseed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_random_word (o_random_word),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void refill_bank(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] prev;
        word_bank[0] = seed;
        for (int i = 1; i < STATE_WORDS; i++) begin
            prev = word_bank[i-1];
            word_bank[i] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
        end
        bank_pos = STATE_WORDS;
    endfunction

    // in place, so late words already see the regenerated early ones
    function automatic void twist_bank();
        logic [WORD_W-1:0] y;
        for (int k = 0; k < STATE_WORDS; k++) begin
            y = (word_bank[k] & UPPER_MASK) | (word_bank[(k + 1) % STATE_WORDS] & LOWER_MASK);
            word_bank[k] = word_bank[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1)
                           ^ (y[0] ? MATRIX_A : '0);
        end
        bank_pos = 0;
    endfunction

    function automatic logic [WORD_W-1:0] draw_word(input t_cmd_kind kind);
        logic [WORD_W-1:0] y;
        if (kind == CMD_RESEED_DRAW) refill_bank(seed_shadow);
        if (bank_pos >= STATE_WORDS) begin
            // never seeded: the boot seed is used whatever the register holds
            if (bank_pos != STATE_WORDS) refill_bank(BOOT_SEED);
            twist_bank();
        end
        y = word_bank[bank_pos];
        bank_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    function automatic void note_error(input string what, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
        if (error_count < 10)
            $display("[%0t] %s: expected %08h, got %08h", $realtime, what, want, got);
        error_count++;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_reseed   <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                awaited_words.push_back(draw_word(cur_cmd));
                in_gap = pick_gap();
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap == 0 && pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    i_in_valid <= 1'b1;
                    i_reseed   <= (cur_cmd == CMD_RESEED_DRAW);
                end else begin
                    if (in_gap > 0) in_gap--;
                    i_in_valid <= 1'b0;
                    i_reseed   <= 1'($urandom_range(0, 1));
                end
            end
        end
    end

    // result monitor and back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_words.size() == 0)
                    note_error("word with no request outstanding", '0, o_random_word);
                else if (awaited_words[0] !== o_random_word)
                    note_error("random_word mismatch", awaited_words[0], o_random_word);
                if (awaited_words.size() > 0) void'(awaited_words.pop_front());
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                stall_left = pick_gap();
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("mersenne_twister_generator regression: fail");
            $finish;
        end
    end

    task automatic write_seed(input logic [WORD_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        seed_shadow = value;
        @(negedge i_clk);
    endtask

    task automatic settle();
        while (pending_cmds.size() > 0 || i_in_valid || awaited_words.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_cmds(input int count, input int reseed_pct);
        for (int n = 0; n < count; n++)
            pending_cmds.push_back(($urandom_range(0, 99) < reseed_pct) ?
                                   CMD_RESEED_DRAW : CMD_DRAW);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register written before any reseed: plain draws still start from the boot seed
        write_seed(32'h1234_5678);
        pending_cmds = '{CMD_DRAW, CMD_DRAW, CMD_RESEED_DRAW, CMD_DRAW};
        settle();
        write_seed('0);
        pending_cmds = '{CMD_RESEED_DRAW, CMD_DRAW, CMD_DRAW};
        settle();
        write_seed('1);
        pending_cmds = '{CMD_RESEED_DRAW, CMD_RESEED_DRAW, CMD_DRAW};
        settle();
        // new seed without reseed leaves the store alone until the reseed
        write_seed(BOOT_SEED);
        pending_cmds = '{CMD_DRAW, CMD_DRAW, CMD_RESEED_DRAW, CMD_DRAW};
        settle();

        // long run of plain draws so the used-up store is regenerated mid-stream
        write_seed($urandom);
        pending_cmds.push_back(CMD_RESEED_DRAW);
        queue_cmds(640, 0);
        settle();

        calm = 1'b1;
        write_seed($urandom);
        queue_cmds(30, 25);
        settle();
        calm = 1'b0;

        write_seed('1);
        queue_cmds(30, 25);
        settle();

        if (error_count == 0 && awaited_words.size() == 0)
            $display("mersenne_twister_generator regression: pass");
        else
            $display("mersenne_twister_generator regression: fail");
        $finish;
    end

endmodule
